### hdl/abkf_pkg.sv
`timescale 1ns / 1ps

package abkf_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int MS_W      = 16;
    localparam int WIDE_W    = 40;
    localparam int NUM_W     = 56;
    localparam int QUO_W     = 31;
    localparam int REM_W     = 33;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 31;

    localparam logic [CFG_W-1:0] APN_RESET = 31'd16777;
    localparam logic [CFG_W-1:0] BPN_RESET = 31'd5033;
    localparam logic [CFG_W-1:0] MN_RESET  = 31'd167772;

    localparam int DT_FRAC_W   = 21;
    localparam int DT_RECIP_W  = 22;
    localparam int DT_PROD_W   = DT_FRAC_W + DT_RECIP_W;
    localparam int DT_RECIP_SH = 28;
    localparam logic [DATA_W-1:0]     DT_WHOLE    = 32'd16777;
    localparam logic [DT_FRAC_W-1:0]  DT_FRAC_MUL = 21'd27;
    localparam logic [DT_FRAC_W-1:0]  DT_FRAC_ADD = 21'd62;
    localparam logic [DT_RECIP_W-1:0] DT_RECIP    = 22'd2147484;

    localparam logic OPC_UPDATE = 1'b0;
    localparam logic OPC_SET    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_APN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MN  = 2'd2;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [ST_W-1:0] ST_DECODE   = 3'd1;
    localparam logic [ST_W-1:0] ST_DIV_INIT = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV_RUN  = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV_END  = 3'd4;
    localparam logic [ST_W-1:0] ST_MUL      = 3'd5;
    localparam logic [ST_W-1:0] ST_ADD      = 3'd6;
    localparam logic [ST_W-1:0] ST_FINISH   = 3'd7;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ANG_PRED  = 4'd0;
    localparam logic [OP_W-1:0] OP_T_PRED    = 4'd1;
    localparam logic [OP_W-1:0] OP_P00_PRED  = 4'd2;
    localparam logic [OP_W-1:0] OP_P11_PRED  = 4'd3;
    localparam logic [OP_W-1:0] OP_ANG_CORR  = 4'd4;
    localparam logic [OP_W-1:0] OP_BIA_CORR  = 4'd5;
    localparam logic [OP_W-1:0] OP_P10_CORR  = 4'd6;
    localparam logic [OP_W-1:0] OP_P00_CORR  = 4'd7;
    localparam logic [OP_W-1:0] OP_P11_CORR  = 4'd8;
    localparam logic [OP_W-1:0] OP_P01_CORR  = 4'd9;

    localparam int DSEL_W = 2;
    localparam logic [DSEL_W-1:0] DIV_DT = 2'd0;
    localparam logic [DSEL_W-1:0] DIV_K0 = 2'd1;
    localparam logic [DSEL_W-1:0] DIV_K1 = 2'd2;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -40'sd2147483648;

    typedef struct packed {
        logic [ST_W-1:0]   step;
        logic [OP_W-1:0]   op;
        logic [DSEL_W-1:0] dsel;
        logic              load;
    } t_cmd;

    typedef struct packed {
        logic short_path;
        logic out_free;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            return 32'sh80000000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [WIDE_W-1:0] sx40(input logic signed [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

### hdl/abkf_ctrl.sv
`timescale 1ns / 1ps

module abkf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  abkf_pkg::t_stat  i_stat,
    output abkf_pkg::t_cmd   o_cmd
);
    import abkf_pkg::*;

    logic [ST_W-1:0]   r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [DSEL_W-1:0] r_dsel, n_dsel;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              load;

    assign load       = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd.step = r_state;
        o_cmd.op   = r_op;
        o_cmd.dsel = r_dsel;
        o_cmd.load = load;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_dsel  = r_dsel;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.short_path) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_DIV_INIT;
                    n_dsel  = DIV_DT;
                end
            end
            ST_DIV_INIT: begin
                if (r_dsel == DIV_DT) begin
                    n_state = ST_MUL;
                    n_op    = OP_ANG_PRED;
                end else begin
                    n_state = ST_DIV_RUN;
                    n_cnt   = CNT_W'(DIV_STEPS - 1);
                end
            end
            ST_DIV_RUN: begin
                if (r_cnt == '0) begin
                    n_state = ST_DIV_END;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DIV_END: begin
                case (r_dsel)
                    DIV_K0: begin
                        n_state = ST_DIV_INIT;
                        n_dsel  = DIV_K1;
                    end
                    DIV_K1: begin
                        n_state = ST_MUL;
                        n_op    = OP_ANG_CORR;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_op == OP_P11_PRED) begin
                    n_state = ST_DIV_INIT;
                    n_dsel  = DIV_K0;
                end else if (r_op == OP_P01_CORR) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_MUL;
                    n_op    = r_op + 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_ANG_PRED;
            r_dsel  <= DIV_DT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_dsel  <= n_dsel;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/abkf_dp.sv
`timescale 1ns / 1ps

module abkf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  abkf_pkg::t_cmd                    i_cmd,
    output abkf_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [abkf_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_opcode,
    input  logic [abkf_pkg::AXIS_W-1:0]       i_axis,
    input  logic signed [abkf_pkg::DATA_W-1:0] i_measured_angle,
    input  logic signed [abkf_pkg::DATA_W-1:0] i_gyro_rate,
    input  logic [abkf_pkg::MS_W-1:0]         i_loop_time_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [abkf_pkg::DATA_W-1:0] o_angle_estimate
);
    import abkf_pkg::*;

    logic [CFG_W-1:0] r_apn, r_bpn, r_mn;

    logic signed [DATA_W-1:0] r_ang_mem [AXES];
    logic signed [DATA_W-1:0] r_bia_mem [AXES];
    logic signed [DATA_W-1:0] r_paa_mem [AXES];
    logic signed [DATA_W-1:0] r_pab_mem [AXES];
    logic signed [DATA_W-1:0] r_pba_mem [AXES];
    logic signed [DATA_W-1:0] r_pbb_mem [AXES];

    logic                     r_opcode;
    logic [AXIS_W-1:0]        r_axis;
    logic signed [DATA_W-1:0] r_meas, r_rate;
    logic [MS_W-1:0]          r_ms;

    logic signed [DATA_W-1:0] r_ang, r_bia, r_p00, r_p01, r_p10, r_p11;
    logic signed [DATA_W-1:0] r_dt, r_t, r_t2, r_k0, r_k1, r_diff;
    logic signed [REM_W-1:0]  r_s;
    logic signed [2*DATA_W-1:0] r_prod;

    logic [DATA_W-1:0]    r_dt_whole;
    logic [DT_FRAC_W-1:0] r_dt_frac;

    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_nlo;
    logic [QUO_W-1:0]  r_q;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg, r_ovf, r_zero;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out;

    logic                       bad_axis;
    logic                       out_free;
    logic                       finish;
    logic signed [2*DATA_W-1:0] rounded;
    logic signed [DATA_W-1:0]   m;
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [DATA_W-1:0]   div_num;
    logic [DATA_W-1:0]          num_mag, s_mag;
    logic [NUM_W-1:0]           n_init;
    logic [DATA_W-1:0]          d_init;
    logic                       ovf_init;
    logic [REM_W:0]             trial;
    logic                       ge;
    logic signed [DATA_W-1:0]   quo;
    logic signed [DATA_W-1:0]   div_res;
    logic [DT_PROD_W-1:0]       dt_prod;

    assign bad_axis = (32'(r_axis) >= AXES);
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (i_cmd.step == ST_FINISH) && out_free;

    always_comb begin
        o_stat.short_path = (r_opcode == OPC_SET) || bad_axis;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_out;

    // Q8.24 product: add half an LSB and floor, which rounds half toward plus infinity.
    assign rounded = r_prod + 64'sd8388608;
    assign m       = sat32(rounded[2*DATA_W-1:24]);

    // The loop time in Q8.24 is 16777 whole counts per millisecond plus the remainder
    // (ms * 216 + 500) / 1000, which reduces to (ms * 27 + 62) / 125 and is taken by a
    // reciprocal multiplication.
    assign dt_prod = DT_PROD_W'(r_dt_frac) * DT_PROD_W'(DT_RECIP);

    always_comb begin
        case (i_cmd.op)
            OP_ANG_PRED: begin
                mul_a = r_dt;
                mul_b = sat32(sx40(r_rate) - sx40(r_bia));
            end
            OP_T_PRED: begin
                mul_a = r_dt;
                mul_b = r_p11;
            end
            OP_P00_PRED: begin
                mul_a = r_dt;
                mul_b = r_t;
            end
            OP_P11_PRED: begin
                mul_a = {1'b0, r_bpn};
                mul_b = r_dt;
            end
            OP_ANG_CORR: begin
                mul_a = r_k0;
                mul_b = r_diff;
            end
            OP_BIA_CORR: begin
                mul_a = r_k1;
                mul_b = r_diff;
            end
            OP_P10_CORR: begin
                mul_a = r_k1;
                mul_b = r_p00;
            end
            OP_P00_CORR: begin
                mul_a = r_k0;
                mul_b = r_p00;
            end
            OP_P11_CORR: begin
                mul_a = r_k1;
                mul_b = r_p01;
            end
            OP_P01_CORR: begin
                mul_a = r_k0;
                mul_b = r_p01;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_num  = (i_cmd.dsel == DIV_K0) ? r_p00 : r_p10;
        num_mag  = div_num[DATA_W-1] ? DATA_W'(-div_num) : DATA_W'(div_num);
        s_mag    = r_s[REM_W-1] ? DATA_W'(-r_s) : DATA_W'(r_s);
        n_init   = {num_mag, 24'd0};
        d_init   = s_mag;
        ovf_init = {{(DATA_W-(NUM_W-QUO_W)){1'b0}}, n_init[NUM_W-1:QUO_W]} >= d_init;
        trial    = {r_rem, r_nlo[QUO_W-1]};
        ge       = trial >= {2'b00, r_dvs};
        quo      = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (r_zero) begin
            div_res = '0;
        end else if (r_ovf) begin
            div_res = r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            div_res = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn       <= APN_RESET;
            r_bpn       <= BPN_RESET;
            r_mn        <= MN_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_ang_mem[k] <= '0;
                r_bia_mem[k] <= '0;
                r_paa_mem[k] <= '0;
                r_pab_mem[k] <= '0;
                r_pba_mem[k] <= '0;
                r_pbb_mem[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_APN: r_apn <= i_cfg_data;
                    CFG_BPN: r_bpn <= i_cfg_data;
                    CFG_MN:  r_mn  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
                if (!bad_axis) begin
                    if (r_opcode == OPC_SET) begin
                        r_ang_mem[r_axis] <= r_meas;
                    end else begin
                        r_ang_mem[r_axis] <= r_ang;
                        r_bia_mem[r_axis] <= r_bia;
                        r_paa_mem[r_axis] <= r_p00;
                        r_pab_mem[r_axis] <= r_p01;
                        r_pba_mem[r_axis] <= r_p10;
                        r_pbb_mem[r_axis] <= r_p11;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_axis   <= i_axis;
            r_meas   <= i_measured_angle;
            r_rate   <= i_gyro_rate;
            r_ms     <= i_loop_time_ms;
        end
        if (finish) begin
            if (bad_axis) begin
                r_out <= '0;
            end else if (r_opcode == OPC_SET) begin
                r_out <= r_meas;
            end else begin
                r_out <= r_ang;
            end
        end
        case (i_cmd.step)
            ST_DECODE: begin
                r_dt_whole <= DATA_W'(r_ms) * DT_WHOLE;
                r_dt_frac  <= DT_FRAC_W'(r_ms) * DT_FRAC_MUL + DT_FRAC_ADD;
                if (!bad_axis) begin
                    r_ang <= r_ang_mem[r_axis];
                    r_bia <= r_bia_mem[r_axis];
                    r_p00 <= r_paa_mem[r_axis];
                    r_p01 <= r_pab_mem[r_axis];
                    r_p10 <= r_pba_mem[r_axis];
                    r_p11 <= r_pbb_mem[r_axis];
                end
            end
            ST_DIV_INIT: begin
                if (i_cmd.dsel == DIV_DT) begin
                    r_dt <= $signed(r_dt_whole
                                    + DATA_W'(dt_prod[DT_PROD_W-1:DT_RECIP_SH]));
                end
                r_rem  <= {{(REM_W-(NUM_W-QUO_W)){1'b0}}, n_init[NUM_W-1:QUO_W]};
                r_nlo  <= n_init[QUO_W-1:0];
                r_q    <= '0;
                r_dvs  <= d_init;
                r_ovf  <= ovf_init;
                r_zero <= (i_cmd.dsel != DIV_DT) && (r_s == '0);
                r_neg  <= (i_cmd.dsel != DIV_DT) && (div_num[DATA_W-1] ^ r_s[REM_W-1]);
            end
            ST_DIV_RUN: begin
                r_rem <= ge ? REM_W'(trial - {2'b00, r_dvs}) : REM_W'(trial);
                r_nlo <= {r_nlo[QUO_W-2:0], 1'b0};
                r_q   <= {r_q[QUO_W-2:0], ge};
            end
            ST_DIV_END: begin
                case (i_cmd.dsel)
                    DIV_K0:  r_k0 <= div_res;
                    DIV_K1:  r_k1 <= div_res;
                    default: begin
                    end
                endcase
            end
            ST_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            ST_ADD: begin
                case (i_cmd.op)
                    OP_ANG_PRED: r_ang <= sat32(sx40(r_ang) + sx40(m));
                    OP_T_PRED: begin
                        r_t  <= sat32(sx40(m) - sx40(r_p01) - sx40(r_p10)
                                      + {{(WIDE_W-CFG_W){1'b0}}, r_apn});
                        r_t2 <= m;
                    end
                    OP_P00_PRED: begin
                        r_p00 <= sat32(sx40(r_p00) + sx40(m));
                        r_p01 <= sat32(sx40(r_p01) - sx40(r_t2));
                        r_p10 <= sat32(sx40(r_p10) - sx40(r_t2));
                    end
                    OP_P11_PRED: begin
                        r_p11  <= sat32(sx40(r_p11) + sx40(m));
                        r_s    <= {r_p00[DATA_W-1], r_p00} + {2'b00, r_mn};
                        r_diff <= sat32(sx40(r_meas) - sx40(r_ang));
                    end
                    OP_ANG_CORR: r_ang <= sat32(sx40(r_ang) + sx40(m));
                    OP_BIA_CORR: r_bia <= sat32(sx40(r_bia) + sx40(m));
                    OP_P10_CORR: r_p10 <= sat32(sx40(r_p10) - sx40(m));
                    OP_P00_CORR: r_p00 <= sat32(sx40(r_p00) - sx40(m));
                    OP_P11_CORR: r_p11 <= sat32(sx40(r_p11) - sx40(m));
                    OP_P01_CORR: r_p01 <= sat32(sx40(r_p01) - sx40(m));
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps

// Two-state angle and gyro bias Kalman filter with independent state for each axis.
// A filter update word is dominated by two passes of the shared restoring divider for
// the gains; it also runs ten products through the single shared 32 by 32 multiplier
// and converts the loop time by reciprocal multiplication. A set-angle word, or a
// word for an axis that does not exist, skips the divider and the multiplier. The
// input is accepted only while the controller is idle. A finished word waits in the
// output register; while it is stalled there, the next word is still accepted but
// cannot finish until the register is free.

module angle_bias_kalman_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [abkf_pkg::AXIS_W-1:0]       i_axis,
    input  logic signed [abkf_pkg::DATA_W-1:0] i_measured_angle,
    input  logic signed [abkf_pkg::DATA_W-1:0] i_gyro_rate,
    input  logic [abkf_pkg::MS_W-1:0]         i_loop_time_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [abkf_pkg::DATA_W-1:0] o_angle_estimate,
    input  logic                              i_cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [abkf_pkg::CFG_W-1:0]        i_cfg_data
);
    import abkf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    abkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    abkf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_axis           (i_axis),
        .i_measured_angle (i_measured_angle),
        .i_gyro_rate      (i_gyro_rate),
        .i_loop_time_ms   (i_loop_time_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_angle_estimate (o_angle_estimate)
    );

endmodule
